@@ design/tdcsm_pkg.sv @@
// Shared types, codes and helpers for the table-driven character state machine.
// Depends on nothing; every other design file refers to it by scoped names.

package tdcsm_pkg;

  localparam int STATE_W  = 4;
  localparam int COUNT_W  = 5;
  localparam int CHAR_W   = 8;
  localparam int ACTION_W = 8;
  localparam int CFG_IDX_W = 1;

  localparam int MAX_STATES = 16;
  localparam int ROW_SLOTS  = 8;

  localparam logic [COUNT_W-1:0] STATE_COUNT_RST   = 5'd16;
  localparam logic [STATE_W-1:0] INITIAL_STATE_RST = 4'd0;

  typedef enum logic [1:0] {
    OP_STEP   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_REINIT = 2'd2,
    OP_MARK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_EXACT   = 2'd0,
    KIND_LOWER   = 2'd1,
    KIND_UPPER   = 2'd2,
    KIND_DEFAULT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ABSENT     = 2'd1,
    ST_BAD_NEXT   = 2'd2,
    ST_NO_DEFAULT = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STATE_COUNT   = 1'b0,
    CFG_INITIAL_STATE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]          operation;
    logic [CHAR_W-1:0]   symbol;
    logic [3:0]          row_index;
    logic [2:0]          slot_index;
    logic [1:0]          slot_kind;
    logic [CHAR_W-1:0]   slot_char;
    logic [STATE_W-1:0]  slot_next;
    logic [ACTION_W-1:0] slot_action;
    logic                slot_has_action;
    logic                row_present;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [STATE_W-1:0]  old_state;
    logic [STATE_W-1:0]  new_state;
    logic [ACTION_W-1:0] action_id;
    logic                action_valid;
    logic [2:0]          chosen_slot;
  } out_item_t;

  // One transition slot as stored in the table (23 bits).
  typedef struct packed {
    logic [1:0]          kind;
    logic [CHAR_W-1:0]   ch;
    logic [STATE_W-1:0]  target;
    logic [ACTION_W-1:0] action;
    logic                has_action;
  } slot_t;

  typedef struct packed {
    logic load;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

  function automatic logic [CHAR_W-1:0] fold_lower(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) r = c + 8'h20;
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] fold_upper(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) r = c - 8'h20;
    return r;
  endfunction

  function automatic logic slot_match(input slot_t s, input logic [CHAR_W-1:0] sym);
    logic m;
    m = 1'b0;
    unique case (s.kind)
      KIND_EXACT:   m = (sym == s.ch);
      KIND_LOWER:   m = (fold_lower(sym) == s.ch);
      KIND_UPPER:   m = (fold_upper(sym) == s.ch);
      KIND_DEFAULT: m = 1'b1;
    endcase
    return m;
  endfunction

endpackage

@@ design/table_driven_char_state_machine_top.sv @@
// Table-driven character state machine: one result word per input word.
// An accepted word has its row read registered, then compare/commit loads the
// output register, waiting while it stalls; no new word is taken before the commit.
// A new word is taken while the previous result waits at the output register.
// Reset (rst, synchronous): state = initial_state reset value, all rows absent,
// configuration at reset values; table contents are not cleared, no clearing pass.

module table_driven_char_state_machine_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tdcsm_pkg::in_item_t             in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tdcsm_pkg::out_item_t            out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tdcsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tdcsm_pkg::COUNT_W-1:0]   cfg_data
);

  tdcsm_pkg::dp_cmd_t    cmd;
  tdcsm_pkg::dp_status_t sts;

  // configuration writes are always accepted and take effect in the next cycle
  assign cfg_ready = 1'b1;

  tdcsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tdcsm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ design/tdcsm_ctrl.sv @@
// Controller for the table-driven character state machine: accepts a word,
// has its row read registered, then commits when the output register frees.
// Depends on tdcsm_pkg.

module tdcsm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tdcsm_pkg::dp_status_t sts,
  output tdcsm_pkg::dp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } ctrl_state_t;

  ctrl_state_t state, state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (!sts.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready   = (state == S_IDLE);
  assign cmd.load   = (state == S_IDLE) && in_valid;
  // hold the looked-up row until the output register can take the result
  assign cmd.commit = (state == S_EXEC) && !sts.out_busy;

  a_load_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !in_ready && (state == S_EXEC))
    else $error("accepted word did not move controller to execute");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) && sts.out_busy |=> (state == S_EXEC) && !cmd.load)
    else $error("controller left execute while output was stalled");

endmodule

@@ design/tdcsm_datapath.sv @@
// Datapath: transition table memory, row-present bits, configuration and state
// registers, parallel slot compare with first-match select, output register.
// Depends on tdcsm_pkg; driven by tdcsm_ctrl through dp_cmd_t.

module tdcsm_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  tdcsm_pkg::dp_cmd_t                  cmd,
  output tdcsm_pkg::dp_status_t               sts,
  input  tdcsm_pkg::in_item_t                 in_data,
  input  logic                                cfg_valid,
  input  logic [tdcsm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tdcsm_pkg::COUNT_W-1:0]       cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tdcsm_pkg::out_item_t                out_data
);

  localparam int ROW_AW  = $clog2(tdcsm_pkg::MAX_STATES);
  localparam int SLOT_AW = $clog2(tdcsm_pkg::ROW_SLOTS);

  tdcsm_pkg::slot_t [tdcsm_pkg::ROW_SLOTS-1:0] mem [tdcsm_pkg::MAX_STATES];
  tdcsm_pkg::slot_t [tdcsm_pkg::ROW_SLOTS-1:0] rd_row;

  tdcsm_pkg::in_item_t                item;
  logic [tdcsm_pkg::STATE_W-1:0]      cur_state;
  logic [tdcsm_pkg::COUNT_W-1:0]      state_count;
  logic [tdcsm_pkg::STATE_W-1:0]      initial_state;
  logic [tdcsm_pkg::MAX_STATES-1:0]   row_valid;

  logic [31:0]        cur_ext, row_ext, slot_ext;
  logic               cur_in_range, row_in_range, slot_in_range, row_ok;
  logic [ROW_AW-1:0]  cur_addr, row_addr;
  logic [tdcsm_pkg::ROW_SLOTS-1:0] match;
  logic               hit;
  logic [SLOT_AW-1:0] pick;
  tdcsm_pkg::slot_t   sel;
  tdcsm_pkg::slot_t   wr_slot;
  tdcsm_pkg::out_item_t res;

  assign cur_ext       = 32'(cur_state);
  assign row_ext       = 32'(item.row_index);
  assign slot_ext      = 32'(item.slot_index);
  assign cur_in_range  = cur_ext < 32'(tdcsm_pkg::MAX_STATES);
  assign row_in_range  = row_ext < 32'(tdcsm_pkg::MAX_STATES);
  assign slot_in_range = slot_ext < 32'(tdcsm_pkg::ROW_SLOTS);
  assign cur_addr      = cur_ext[ROW_AW-1:0];
  assign row_addr      = row_ext[ROW_AW-1:0];
  assign row_ok        = cur_in_range && row_valid[cur_addr];

  assign wr_slot.kind       = item.slot_kind;
  assign wr_slot.ch         = item.slot_char;
  assign wr_slot.target     = item.slot_next;
  assign wr_slot.action     = item.slot_action;
  assign wr_slot.has_action = item.slot_has_action;

  // Row table: one registered row read per accepted word, per-slot write enables.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item   <= in_data;
      rd_row <= mem[cur_addr];
    end
    if (cmd.commit && (item.operation == tdcsm_pkg::OP_WRITE) &&
        row_in_range && slot_in_range) begin
      for (int s = 0; s < tdcsm_pkg::ROW_SLOTS; s++) begin
        if (slot_ext == 32'(s)) mem[row_addr][s] <= wr_slot;
      end
    end
  end

  // Compare every slot of the row, take the lowest matching index.
  always_comb begin
    hit  = 1'b0;
    pick = '0;
    for (int i = 0; i < tdcsm_pkg::ROW_SLOTS; i++) begin
      match[i] = tdcsm_pkg::slot_match(rd_row[i], item.symbol);
    end
    for (int i = tdcsm_pkg::ROW_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit  = 1'b1;
        pick = SLOT_AW'(i);
      end
    end
    sel = rd_row[pick];
  end

  always_comb begin
    res.status       = tdcsm_pkg::ST_OK;
    res.old_state    = cur_state;
    res.new_state    = cur_state;
    res.action_id    = '0;
    res.action_valid = 1'b0;
    res.chosen_slot  = '0;
    unique case (item.operation)
      tdcsm_pkg::OP_STEP: begin
        if (!row_ok) begin
          res.status = tdcsm_pkg::ST_ABSENT;
        end else if (!hit) begin
          res.status = tdcsm_pkg::ST_NO_DEFAULT;
        end else begin
          res.chosen_slot = 3'(pick);
          if (sel.has_action) begin
            res.action_id    = sel.action;
            res.action_valid = 1'b1;
          end
          // bad target still reports the action, state holds
          if (tdcsm_pkg::COUNT_W'(sel.target) >= state_count) begin
            res.status = tdcsm_pkg::ST_BAD_NEXT;
          end else begin
            res.new_state = sel.target;
          end
        end
      end
      tdcsm_pkg::OP_REINIT: res.new_state = initial_state;
      tdcsm_pkg::OP_WRITE, tdcsm_pkg::OP_MARK: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_state     <= tdcsm_pkg::INITIAL_STATE_RST;
      state_count   <= tdcsm_pkg::STATE_COUNT_RST;
      initial_state <= tdcsm_pkg::INITIAL_STATE_RST;
      row_valid     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          tdcsm_pkg::CFG_STATE_COUNT:   state_count   <= cfg_data;
          tdcsm_pkg::CFG_INITIAL_STATE: initial_state <= cfg_data[tdcsm_pkg::STATE_W-1:0];
        endcase
      end
      if (cmd.commit) begin
        cur_state <= res.new_state;
        if ((item.operation == tdcsm_pkg::OP_MARK) && row_in_range) begin
          row_valid[row_addr] <= item.row_present;
        end
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) out_data <= res;
  end

  assign sts.out_busy = out_valid && !out_ready;

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed word not presented at output");

  a_error_holds_state: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && (res.status != tdcsm_pkg::ST_OK) |=> cur_state == $past(cur_state))
    else $error("state moved on an error status");

  a_error_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != tdcsm_pkg::ST_OK) |->
      out_data.old_state == out_data.new_state)
    else $error("error word reports a state change");

endmodule
